FILE: hdl/jbt_pkg.sv
// jbt_pkg: types, constants and character class functions for the json byte tokenizer
package jbt_pkg;

	localparam longint unsigned MAX_TEXT = 65535;
	localparam logic [15:0] OFFSET_CAP = (MAX_TEXT < 64'd65535) ? 16'(MAX_TEXT) : 16'hFFFF;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [39:0] WORD_NULL = 40'h00_6E75_6C6C;
	localparam logic [39:0] WORD_TRUE = 40'h00_7472_7565;
	localparam logic [39:0] WORD_FALSE = 40'h66_616C_7365;
	localparam logic [15:0] WORD4_LEN = 16'd4;
	localparam logic [15:0] WORD5_LEN = 16'd5;
	localparam logic [15:0] PREFIX_LEN = 16'd5;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5A;

	localparam logic [1:0] DOT_MAX = 2'd2;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_STR   = 3'd1,
		MODE_SPACE = 3'd2,
		MODE_NUM   = 3'd3,
		MODE_WORD  = 3'd4
	} scan_mode_t;

	typedef enum logic [3:0] {
		TOK_LBRACE  = 4'd0,
		TOK_RBRACE  = 4'd1,
		TOK_LBRACK  = 4'd2,
		TOK_RBRACK  = 4'd3,
		TOK_COLON   = 4'd4,
		TOK_COMMA   = 4'd5,
		TOK_STRING  = 4'd6,
		TOK_SPACE   = 4'd7,
		TOK_NUMBER  = 4'd8,
		TOK_NULL    = 4'd9,
		TOK_TRUE    = 4'd10,
		TOK_FALSE   = 4'd11,
		TOK_UNKNOWN = 4'd12,
		TOK_END     = 4'd13
	} tok_type_t;

	typedef enum logic {
		KIND_TEXT = 1'b0,
		KIND_END  = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] text_byte;
	} in_item_t;

	typedef struct packed {
		tok_type_t   token_type;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic        last_of_run;
	} token_t;

	typedef struct packed {
		token_t     tok0;
		token_t     tok1;
		logic [1:0] n;
		scan_mode_t mode;
	} scan_out_t;

	typedef struct packed {
		logic              has_room;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) || (b == CH_CR);
	endfunction

	function automatic logic is_num(input logic [7:0] b);
		return ((b >= CH_0) && (b <= CH_9)) || (b == CH_DOT);
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ));
	endfunction

	function automatic logic is_punct(input logic [7:0] b);
		return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LBRACK) ||
			(b == CH_RBRACK) || (b == CH_COLON) || (b == CH_COMMA);
	endfunction

	function automatic tok_type_t punct_type(input logic [7:0] b);
		tok_type_t t;
		t = TOK_UNKNOWN;
		unique case (b)
			CH_LBRACE: t = TOK_LBRACE;
			CH_RBRACE: t = TOK_RBRACE;
			CH_LBRACK: t = TOK_LBRACK;
			CH_RBRACK: t = TOK_RBRACK;
			CH_COLON: t = TOK_COLON;
			CH_COMMA: t = TOK_COMMA;
			default: t = TOK_UNKNOWN;
		endcase
		return t;
	endfunction

endpackage

FILE: hdl/jbt_scan.sv
// jbt_scan: tokenizer state and per-beat token decode
module jbt_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  jbt_pkg::in_item_t item,
	output jbt_pkg::scan_out_t res
);

	jbt_pkg::scan_mode_t mode_q, mode_n;
	logic [15:0] off_q, off_n;
	logic [15:0] start_q, start_n;
	logic [15:0] cnt_q, cnt_n;
	logic [1:0]  dot_q, dot_n;
	logic [39:0] prefix_q, prefix_n;

	logic [7:0]  b;
	logic        is_end;
	logic        cont;
	logic        is_quote;
	logic [15:0] off_inc;
	logic        cnt_room;
	jbt_pkg::tok_type_t fl_type;

	logic        pre_v, post_v;
	jbt_pkg::token_t pre_tok, post_tok;
	logic        idle_after;

	assign b = item.text_byte;
	assign is_end = (item.kind == jbt_pkg::KIND_END);
	assign is_quote = (b == jbt_pkg::CH_QUOTE);
	assign off_inc = (off_q < jbt_pkg::OFFSET_CAP) ? off_q + 16'd1 : jbt_pkg::OFFSET_CAP;
	assign cnt_room = (cnt_q < jbt_pkg::LEN_MAX);
	assign cont = ((mode_q == jbt_pkg::MODE_SPACE) && jbt_pkg::is_space(b)) ||
		((mode_q == jbt_pkg::MODE_NUM) && jbt_pkg::is_num(b)) ||
		((mode_q == jbt_pkg::MODE_WORD) && jbt_pkg::is_letter(b));
	assign idle_after = (mode_q == jbt_pkg::MODE_IDLE) ||
		((mode_q != jbt_pkg::MODE_STR) && !cont);

	// type of the open run when it is closed
	always_comb begin
		fl_type = jbt_pkg::TOK_UNKNOWN;
		unique case (mode_q)
			jbt_pkg::MODE_SPACE: fl_type = jbt_pkg::TOK_SPACE;
			jbt_pkg::MODE_NUM: begin
				fl_type = (dot_q < jbt_pkg::DOT_MAX) ? jbt_pkg::TOK_NUMBER : jbt_pkg::TOK_UNKNOWN;
			end
			jbt_pkg::MODE_WORD: begin
				priority if ((cnt_q == jbt_pkg::WORD4_LEN) && (prefix_q == jbt_pkg::WORD_NULL)) begin
					fl_type = jbt_pkg::TOK_NULL;
				end else if ((cnt_q == jbt_pkg::WORD4_LEN) && (prefix_q == jbt_pkg::WORD_TRUE)) begin
					fl_type = jbt_pkg::TOK_TRUE;
				end else if ((cnt_q == jbt_pkg::WORD5_LEN) &&
						(prefix_q == jbt_pkg::WORD_FALSE)) begin
					fl_type = jbt_pkg::TOK_FALSE;
				end else begin
					fl_type = jbt_pkg::TOK_UNKNOWN;
				end
			end
			default: fl_type = jbt_pkg::TOK_UNKNOWN;
		endcase
	end

	// tokens caused by this beat: closing token first, then the byte's own token
	always_comb begin
		pre_v = 1'b0;
		post_v = 1'b0;
		pre_tok.token_type = fl_type;
		pre_tok.token_start = start_q;
		pre_tok.token_length = cnt_q;
		pre_tok.last_of_run = 1'b0;
		post_tok.token_type = jbt_pkg::TOK_UNKNOWN;
		post_tok.token_start = off_q;
		post_tok.token_length = 16'd1;
		post_tok.last_of_run = 1'b0;
		if (is_end) begin
			pre_v = (mode_q != jbt_pkg::MODE_IDLE);
			post_v = 1'b1;
			post_tok.token_type = jbt_pkg::TOK_END;
		end else if (mode_q == jbt_pkg::MODE_STR) begin
			pre_v = is_quote;
			pre_tok.token_type = jbt_pkg::TOK_STRING;
		end else begin
			pre_v = (mode_q != jbt_pkg::MODE_IDLE) && !cont;
			if (idle_after) begin
				if (jbt_pkg::is_punct(b)) begin
					post_v = 1'b1;
					post_tok.token_type = jbt_pkg::punct_type(b);
				end else if (!is_quote && !jbt_pkg::is_space(b) && !jbt_pkg::is_num(b) &&
						!jbt_pkg::is_letter(b)) begin
					post_v = 1'b1;
				end
			end
		end
	end

	always_comb begin
		res.mode = mode_q;
		res.n = {1'b0, pre_v} + {1'b0, post_v};
		res.tok0 = pre_v ? pre_tok : post_tok;
		res.tok1 = post_tok;
		res.tok0.last_of_run = !(pre_v && post_v);
		res.tok1.last_of_run = 1'b1;
	end

	// next state
	always_comb begin
		mode_n = mode_q;
		off_n = off_inc;
		start_n = start_q;
		cnt_n = cnt_q;
		dot_n = dot_q;
		prefix_n = prefix_q;
		if (is_end) begin
			mode_n = jbt_pkg::MODE_IDLE;
			off_n = '0;
			start_n = '0;
			cnt_n = '0;
			dot_n = '0;
			prefix_n = '0;
		end else if (mode_q == jbt_pkg::MODE_STR) begin
			if (is_quote) begin
				mode_n = jbt_pkg::MODE_IDLE;
			end else if (cnt_room) begin
				cnt_n = cnt_q + 16'd1;
			end
		end else begin
			if (mode_q != jbt_pkg::MODE_IDLE) begin
				if (cont) begin
					if (cnt_room) begin
						if ((mode_q == jbt_pkg::MODE_WORD) && (cnt_q < jbt_pkg::PREFIX_LEN)) begin
							prefix_n = {prefix_q[31:0], b};
						end
						cnt_n = cnt_q + 16'd1;
					end
					if ((mode_q == jbt_pkg::MODE_NUM) && (b == jbt_pkg::CH_DOT) &&
							(dot_q < jbt_pkg::DOT_MAX)) begin
						dot_n = dot_q + 2'd1;
					end
				end else begin
					mode_n = jbt_pkg::MODE_IDLE;
				end
			end
			if (idle_after && !jbt_pkg::is_punct(b)) begin
				dot_n = '0;
				prefix_n = '0;
				start_n = off_q;
				cnt_n = 16'd1;
				priority if (is_quote) begin
					mode_n = jbt_pkg::MODE_STR;
					start_n = off_inc;
					cnt_n = '0;
				end else if (jbt_pkg::is_space(b)) begin
					mode_n = jbt_pkg::MODE_SPACE;
				end else if (jbt_pkg::is_num(b)) begin
					mode_n = jbt_pkg::MODE_NUM;
					dot_n = (b == jbt_pkg::CH_DOT) ? 2'd1 : 2'd0;
				end else if (jbt_pkg::is_letter(b)) begin
					mode_n = jbt_pkg::MODE_WORD;
					prefix_n = {32'd0, b};
				end else begin
					mode_n = jbt_pkg::MODE_IDLE;
					start_n = start_q;
					cnt_n = cnt_q;
					dot_n = dot_q;
					prefix_n = prefix_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jbt_pkg::MODE_IDLE;
			off_q <= '0;
			start_q <= '0;
			cnt_q <= '0;
			dot_q <= '0;
			prefix_q <= '0;
		end else if (en) begin
			mode_q <= mode_n;
			off_q <= off_n;
			start_q <= start_n;
			cnt_q <= cnt_n;
			dot_q <= dot_n;
			prefix_q <= prefix_n;
		end
	end

endmodule

FILE: hdl/jbt_queue.sv
// jbt_queue: small token queue taking up to two tokens per cycle
module jbt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  jbt_pkg::token_t   push0,
	input  jbt_pkg::token_t   push1,
	output logic              out_valid,
	input  logic              out_ready,
	output jbt_pkg::token_t   out_data,
	output jbt_pkg::q_stat_t  stat
);

	jbt_pkg::token_t mem_q [jbt_pkg::QDEPTH];
	logic [jbt_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [jbt_pkg::QCNT_W-1:0] cnt_q;
	logic pop;
	logic [jbt_pkg::QPTR_W-1:0] wr_p1;

	assign out_valid = (cnt_q != '0);
	assign out_data = mem_q[rd_q];
	assign pop = out_valid && out_ready;
	assign wr_p1 = wr_q + 1'b1;
	assign stat.count = cnt_q;
	assign stat.has_room = (cnt_q <= jbt_pkg::QCNT_W'(jbt_pkg::QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_p1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + jbt_pkg::QPTR_W'(push_n);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + jbt_pkg::QCNT_W'(push_n) - jbt_pkg::QCNT_W'(pop);
		end
	end

endmodule

FILE: hdl/json_byte_tokenizer.sv
// json_byte_tokenizer: top level, input register, token decode and output queue
// flow: a beat is held in the input register, its tokens are decoded from it and are
// written into the queue once the queue has room, and out_data shows the queue head
// throughput: one beat per cycle while the queue has room; a beat giving two tokens
// leaves as two queue entries, and the four-entry queue throttles input through in_ready
// reset: arst_n clears scan state, offsets, input valid and queue pointers
module json_byte_tokenizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  jbt_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output jbt_pkg::token_t   out_data
);

	jbt_pkg::in_item_t item_s1;
	logic valid_s1;
	logic advance;
	jbt_pkg::scan_out_t scan;
	jbt_pkg::q_stat_t q_stat;
	logic [1:0] push_n;

	assign advance = valid_s1 && q_stat.has_room;
	assign in_ready = !valid_s1 || advance;
	assign push_n = advance ? scan.n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	jbt_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.res    (scan)
	);

	jbt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push0     (scan.tok0),
		.push1     (scan.tok1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.stat      (q_stat)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= jbt_pkg::QCNT_W'(jbt_pkg::QDEPTH))
		else $error("token queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && scan.n == 2'd2) |-> (!scan.tok0.last_of_run && scan.tok1.last_of_run))
		else $error("last flag misplaced on two-token beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.kind == jbt_pkg::KIND_END) |=> (scan.mode == jbt_pkg::MODE_IDLE))
		else $error("scan not idle after end beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.kind == jbt_pkg::KIND_END) |->
		(scan.n != 2'd0 && (scan.n == 2'd1 ? scan.tok0.token_type : scan.tok1.token_type)
			== jbt_pkg::TOK_END))
		else $error("end beat without end token");

endmodule
